FILE: hw/rtl/json_array_element_scanner_defines.svh
// Assertion macros for the JSON array element scanner.
`ifndef JSON_ARRAY_ELEMENT_SCANNER_DEFINES_SVH
`define JSON_ARRAY_ELEMENT_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define JAES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define JAES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JAES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define JAES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/jaes_pkg.sv
// Shared types, character codes and status codes of the JSON array element scanner.
package jaes_pkg;

  // Default parameter values
  localparam int unsigned      DEF_MAX_DEPTH    = 255;
  localparam longint unsigned  DEF_MAX_ELEMENTS = 65535;

  // Hard limit of the depth counters
  localparam int unsigned DEPTH_LIMIT = 255;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;
  localparam int BRKT_W   = 8;
  localparam int BRACE_W  = 9;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRKT  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRKT  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_SCAN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_END     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNTERM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRAIL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  // One result item
  typedef struct packed {
    logic                new_element;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  element_count;
  } jaes_result_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

FILE: hw/rtl/jaes_core.sv
// Scan state registers and the per-byte update of the JSON array element scanner.
module jaes_core #(
  parameter int unsigned     MAX_DEPTH    = jaes_pkg::DEF_MAX_DEPTH,
  parameter longint unsigned MAX_ELEMENTS = jaes_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  logic [jaes_pkg::BYTE_W-1:0]     text_byte,
  input  logic                            scan_start,
  output jaes_pkg::jaes_result_t          res
);
  import jaes_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam int unsigned DEPTH_CAP_I = (MAX_DEPTH < DEPTH_LIMIT) ? MAX_DEPTH : DEPTH_LIMIT;
  localparam logic [BRKT_W-1:0]         BRKT_CAP  = BRKT_W'(DEPTH_CAP_I);
  localparam logic signed [BRACE_W-1:0] BRACE_CAP = BRACE_W'(DEPTH_CAP_I);

  logic                      in_quotes_r, in_quotes_nxt;
  logic                      esc_r, esc_nxt;
  logic [BRKT_W-1:0]         brkt_r, brkt_nxt;
  logic signed [BRACE_W-1:0] brace_r, brace_nxt;
  logic                      after_comma_r, after_comma_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      finished_r, finished_nxt;

  // State as seen by this byte (start clears it first and sets the count to one)
  logic                      cur_quotes, cur_esc, cur_comma, cur_fin;
  logic [BRKT_W-1:0]         cur_brkt;
  logic signed [BRACE_W-1:0] cur_brace;
  logic [CNT_W-1:0]          cur_count;
  logic                      newel;
  logic [STATUS_W-1:0]       status;

  always_comb begin
    cur_quotes = scan_start ? 1'b0 : in_quotes_r;
    cur_esc    = scan_start ? 1'b0 : esc_r;
    cur_comma  = scan_start ? 1'b0 : after_comma_r;
    cur_fin    = scan_start ? 1'b0 : finished_r;
    cur_brkt   = scan_start ? '0 : brkt_r;
    cur_brace  = scan_start ? '0 : brace_r;
    cur_count  = scan_start ? CNT_ONE : count_r;

    in_quotes_nxt   = cur_quotes;
    esc_nxt         = cur_esc;
    brkt_nxt        = cur_brkt;
    brace_nxt       = cur_brace;
    after_comma_nxt = cur_comma;
    count_nxt       = cur_count;
    finished_nxt    = cur_fin;
    newel           = 1'b0;
    status          = ST_SCAN;

    priority if (cur_fin) begin
      status = ST_IGNORED;
    end else if (cur_comma && (text_byte == CH_NUL)) begin
      status       = ST_TRAIL;
      finished_nxt = 1'b1;
    end else if (cur_comma && is_space(text_byte)) begin
      status = ST_SCAN;
    end else if (text_byte == CH_NUL) begin
      status       = ST_UNTERM;
      finished_nxt = 1'b1;
    end else begin
      // First non-space byte after a top-level comma opens an element
      if (cur_comma) begin
        after_comma_nxt = 1'b0;
        newel           = 1'b1;
        if (cur_count < CNT_MAX) begin
          count_nxt = cur_count + CNT_ONE;
        end
      end
      esc_nxt = 1'b0;
      // Quote, escape and nesting
      priority if ((text_byte == CH_QUOTE) && !cur_esc) begin
        in_quotes_nxt = !cur_quotes;
      end else if ((text_byte == CH_BSLASH) && !cur_esc) begin
        esc_nxt = 1'b1;
      end else if (!cur_quotes) begin
        priority if ((text_byte == CH_LBRACE) && !cur_esc) begin
          if (cur_brace < BRACE_CAP) begin
            brace_nxt = cur_brace + 9'sd1;
          end
        end else if ((text_byte == CH_RBRACE) && !cur_esc) begin
          if (cur_brace > -BRACE_CAP) begin
            brace_nxt = cur_brace - 9'sd1;
          end
        end else if (text_byte == CH_LBRKT) begin
          if (cur_brkt < BRKT_CAP) begin
            brkt_nxt = cur_brkt + 8'd1;
          end
        end else if (text_byte == CH_RBRKT) begin
          if (cur_brkt != '0) begin
            brkt_nxt = cur_brkt - 8'd1;
          end else begin
            status       = ST_END;
            finished_nxt = 1'b1;
          end
        end else if ((text_byte == CH_COMMA) && (cur_brkt == '0) && (cur_brace == '0)) begin
          after_comma_nxt = 1'b1;
        end else begin
          after_comma_nxt = after_comma_nxt;
        end
      end else begin
        esc_nxt = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r   <= 1'b0;
      esc_r         <= 1'b0;
      brkt_r        <= '0;
      brace_r       <= '0;
      after_comma_r <= 1'b0;
      count_r       <= CNT_ONE;
      finished_r    <= 1'b1;
    end else if (step_en) begin
      in_quotes_r   <= in_quotes_nxt;
      esc_r         <= esc_nxt;
      brkt_r        <= brkt_nxt;
      brace_r       <= brace_nxt;
      after_comma_r <= after_comma_nxt;
      count_r       <= count_nxt;
      finished_r    <= finished_nxt;
    end
  end

  assign res.new_element   = newel;
  assign res.status        = status;
  assign res.element_count = COUNT_W'(count_nxt);

endmodule

FILE: hw/rtl/json_array_element_scanner.sv
// JSON array element scanner with an input register and a result register.
// Path: input register, per-byte state update, then the result register that drives out_.
// Throughput: one byte per cycle while out_stall does not hold a full result register.
// A stalled result holds the input register; one more byte is taken while a result waits.
// Reset (rst_n low, synchronous): pipeline empty, scan state cleared, count one, and the
// scanner idle (status 4) until a byte arrives with scan_start set.
module json_array_element_scanner #(
  parameter int unsigned     MAX_DEPTH    = jaes_pkg::DEF_MAX_DEPTH,
  parameter longint unsigned MAX_ELEMENTS = jaes_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [jaes_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic                              in_scan_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_new_element,
  output logic [jaes_pkg::STATUS_W-1:0]     out_status,
  output logic [jaes_pkg::COUNT_W-1:0]      out_element_count
);
  import jaes_pkg::*;
  `include "json_array_element_scanner_defines.svh"

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;
  logic              out_valid_r, out_valid_nxt;
  jaes_result_t      out_r;
  jaes_result_t      res;
  logic              out_free;
  logic              adv;

  // Handshake: a byte moves on when the result register is free
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r  <= in_text_byte;
      s1_start_r <= in_scan_start;
    end
  end

  jaes_core #(
    .MAX_DEPTH    (MAX_DEPTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .text_byte  (s1_byte_r),
    .scan_start (s1_start_r),
    .res        (res)
  );

  // Result register
  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_element   = out_r.new_element;
  assign out_status        = out_r.status;
  assign out_element_count = out_r.element_count;

  // Checks
  `JAES_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_r, "stall with empty input register")
  `JAES_ASSERT_IMPL(a_no_elem_when_idle, clk, rst_n, adv && (res.status == ST_IGNORED), !res.new_element, "new element while idle")
  `JAES_ASSERT_NEXT(a_out_refill, clk, rst_n, out_valid_r && !out_stall, out_valid_r == $past(adv), "result register refill mismatch")

endmodule

FILE: dv/tb_json_array_element_scanner.sv
// Self-checking JSON array element scanner testbench: directed and random streams, predicted results.
module tb_json_array_element_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import jaes_pkg::*;

  // Whitespace codes that the package does not name
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;

  // Depth limits of the default build
  localparam int unsigned DEPTH_CAP =
    (DEF_MAX_DEPTH < DEPTH_LIMIT) ? DEF_MAX_DEPTH : DEPTH_LIMIT;
  localparam logic [BRKT_W-1:0]         BRKT_HI  = BRKT_W'(DEPTH_CAP);
  localparam logic signed [BRACE_W-1:0] BRACE_HI = BRACE_W'(DEPTH_CAP);
  localparam logic signed [BRACE_W-1:0] BRACE_LO = -BRACE_W'(DEPTH_CAP);

  localparam int RANDOM_BYTES = 150;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              start;
  } text_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_text_byte = '0;
  logic                in_scan_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_new_element;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_element_count;

  json_array_element_scanner u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_scan_start     (in_scan_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_new_element   (out_new_element),
    .out_status        (out_status),
    .out_element_count (out_element_count)
  );

  always #1 clk = ~clk;

  text_item_t   text_q[$];
  jaes_result_t scan_result_q[$];
  int           n_taken = 0;
  int           n_total = 0;
  int           n_mismatch = 0;
  logic         start_next = 1'b0;

  // Scanner state as the testbench sees it
  logic                        sc_quoted;
  logic                        sc_esc;
  logic [BRKT_W-1:0]           sc_brkt;
  logic signed [BRACE_W-1:0]   sc_brace;
  logic                        sc_after_comma;
  longint unsigned             sc_count;
  logic                        sc_done;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic void clear_scan_state();
    sc_quoted      = 1'b0;
    sc_esc         = 1'b0;
    sc_brkt        = '0;
    sc_brace       = '0;
    sc_after_comma = 1'b0;
    sc_count       = 1;
  endfunction

  // Advance the scan by one byte and give the result it produces
  function automatic jaes_result_t scan_byte(input logic [BYTE_W-1:0] b, input logic start);
    jaes_result_t r;
    logic         esc;
    r.new_element = 1'b0;
    r.status      = ST_SCAN;
    if (start) begin
      clear_scan_state();
      sc_done = 1'b0;
    end
    if (sc_done) begin
      r.status = ST_IGNORED;
    end else if (sc_after_comma && b == CH_NUL) begin
      r.status = ST_TRAIL;
      sc_done  = 1'b1;
    end else if (sc_after_comma && is_blank(b)) begin
      r.status = ST_SCAN;
    end else if (b == CH_NUL) begin
      r.status = ST_UNTERM;
      sc_done  = 1'b1;
    end else begin
      esc = sc_esc;
      // first byte of a new element
      if (sc_after_comma) begin
        sc_after_comma = 1'b0;
        r.new_element  = 1'b1;
        if (sc_count < DEF_MAX_ELEMENTS) sc_count++;
      end
      sc_esc = 1'b0;
      if (b == CH_QUOTE && !esc) begin
        sc_quoted = !sc_quoted;
      end else if (b == CH_BSLASH && !esc) begin
        sc_esc = 1'b1;
      end else if (!sc_quoted) begin
        if (b == CH_LBRACE && !esc) begin
          if (sc_brace < BRACE_HI) sc_brace++;
        end else if (b == CH_RBRACE && !esc) begin
          if (sc_brace > BRACE_LO) sc_brace--;
        end else if (b == CH_LBRKT) begin
          if (sc_brkt < BRKT_HI) sc_brkt++;
        end else if (b == CH_RBRKT) begin
          if (sc_brkt != 0) begin
            sc_brkt--;
          end else begin
            r.status = ST_END;
            sc_done  = 1'b1;
          end
        end else if (b == CH_COMMA && sc_brkt == 0 && sc_brace == 0) begin
          sc_after_comma = 1'b1;
        end
      end
    end
    r.element_count = sc_count[COUNT_W-1:0];
    return r;
  endfunction

  // Stimulus building
  task automatic add(input logic [BYTE_W-1:0] b);
    text_q.push_back('{text: b, start: start_next});
    start_next = 1'b0;
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) add(t[i]);
  endtask

  task automatic add_run(input logic [BYTE_W-1:0] b, input int n);
    for (int i = 0; i < n; i++) add(b);
  endtask

  task automatic add_blank();
    int n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: add(CH_SPACE);
        1: add(CH_TAB);
        2: add(CH_LF);
        3: add(CH_VT);
        4: add(CH_FF);
        default: add(CH_CR);
      endcase
    end
  endtask

  // String body: plain text, spaces, structural characters, high bytes and escapes
  task automatic add_string();
    int n;
    n = $urandom_range(0, 6);
    add(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: add(8'($urandom_range(8'h61, 8'h7A)));
        1: begin
          case ($urandom_range(0, 4))
            0: add(CH_LBRACE);
            1: add(CH_RBRACE);
            2: add(CH_LBRKT);
            3: add(CH_RBRKT);
            default: add(CH_COMMA);
          endcase
        end
        2: add(8'($urandom_range(8'h80, 8'hFF)));
        3: begin
          add(CH_BSLASH);
          case ($urandom_range(0, 3))
            0: add(CH_QUOTE);
            1: add(CH_BSLASH);
            2: add(CH_LBRACE);
            default: add_text("n");
          endcase
        end
        default: add(CH_SPACE);
      endcase
    end
    add(CH_QUOTE);
  endtask

  task automatic add_value(input int lvl);
    int n;
    case ($urandom_range(0, (lvl < 2) ? 4 : 2))
      0: begin
        if ($urandom_range(0, 3) == 0) add_text("-");
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add(8'($urandom_range(8'h30, 8'h39)));
      end
      1: add_string();
      2: add_text($urandom_range(0, 1) ? "true" : "null");
      3: begin
        n = $urandom_range(0, 3);
        add(CH_LBRACE);
        for (int i = 0; i < n; i++) begin
          if (i > 0) add(CH_COMMA);
          add_blank();
          add_string();
          add_text(":");
          add_blank();
          add_value(lvl + 1);
        end
        add(CH_RBRACE);
      end
      default: begin
        n = $urandom_range(0, 3);
        add(CH_LBRKT);
        for (int i = 0; i < n; i++) begin
          if (i > 0) add(CH_COMMA);
          add_blank();
          add_value(lvl + 1);
        end
        add(CH_RBRKT);
      end
    endcase
  endtask

  // One array body from its first element on, then its end and some bytes after it
  task automatic add_array();
    int n;
    start_next = 1'b1;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        add_blank();
        add(CH_COMMA);
        add_blank();
      end
      // occasional noise, unbalanced close brace or restart
      case ($urandom_range(0, 29))
        0: add(8'($urandom_range(1, 255)));
        1: add(CH_RBRACE);
        2: start_next = 1'b1;
        default: ;
      endcase
      add_value(0);
    end
    add_blank();
    case ($urandom_range(0, 9))
      6: add(CH_NUL);
      7: begin
        add(CH_COMMA);
        add_blank();
        add(CH_NUL);
      end
      8: begin
        add(CH_COMMA);
        add_blank();
        add(CH_RBRKT);
      end
      9: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add(8'($urandom_range(1, 255)));
        add(CH_NUL);
      end
      default: add(CH_RBRKT);
    endcase
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) add(8'($urandom_range(0, 255)));
  endtask

  // Sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    jaes_result_t r;
    text_item_t   it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // transfer on the input side
      if (in_valid && !in_stall) begin
        r = scan_byte(in_text_byte, in_scan_start);
        scan_result_q.push_back(r);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          it = text_q.pop_front();
          in_valid      <= 1'b1;
          in_text_byte  <= it.text;
          in_scan_start <= it.start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between quiet, random and periodic modes
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin : stall_gen
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        3: out_stall <= ((stall_left % 8) < 3);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : monitor
    jaes_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_result_q.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d",
               out_status, out_element_count);
        n_mismatch++;
      end else begin
        w = scan_result_q.pop_front();
        if (out_new_element !== w.new_element) begin
          $error("new_element: expected %0d, got %0d", w.new_element, out_new_element);
          n_mismatch++;
        end
        if (out_status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_status);
          n_mismatch++;
        end
        if (out_element_count !== w.element_count) begin
          $error("element_count: expected %0d, got %0d", w.element_count, out_element_count);
          n_mismatch++;
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    clear_scan_state();
    sc_done = 1'b1;

    // Idle after reset: bytes without a start are ignored
    add_text("a");
    add(8'hFF);
    // Empty array
    start_next = 1'b1;
    add(CH_RBRKT);
    // Element that starts on the closing bracket
    start_next = 1'b1;
    add_text("1");
    add(CH_COMMA);
    add(CH_TAB);
    add(CH_SPACE);
    add(CH_RBRKT);
    // Braces and escaped quote inside a string, then a trailing comma
    start_next = 1'b1;
    add(CH_QUOTE);
    add(CH_LBRACE);
    add(CH_BSLASH);
    add(CH_QUOTE);
    add(CH_RBRACE);
    add(CH_QUOTE);
    add(CH_COMMA);
    add(CH_NUL);
    add_text("x");
    // Unbalanced close brace hides the comma, then unterminated text
    start_next = 1'b1;
    add(CH_RBRACE);
    add(CH_COMMA);
    add_text("5");
    add(CH_NUL);
    // Escaped bracket outside quotes still nests; high bytes pass through
    start_next = 1'b1;
    add(CH_BSLASH);
    add(CH_LBRKT);
    add(8'hFF);
    add(CH_RBRKT);
    add(CH_RBRKT);

    // Bracket depth saturation
    start_next = 1'b1;
    add_run(CH_LBRKT, 257);
    add_run(CH_RBRKT, 3);
    add(CH_NUL);
    // Brace depth saturation upward
    start_next = 1'b1;
    add_run(CH_LBRACE, 257);
    add(CH_NUL);
    // Brace depth saturation downward; the comma stays hidden
    start_next = 1'b1;
    add_run(CH_RBRACE, 257);
    add(CH_COMMA);
    add_text("1");
    add(CH_NUL);

    // Random arrays
    base = text_q.size();
    while (text_q.size() < base + RANDOM_BYTES) add_array();
    n_total = text_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total || scan_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: json_array_element_scanner.f
+incdir+hw/rtl
hw/rtl/jaes_pkg.sv
hw/rtl/jaes_core.sv
hw/rtl/json_array_element_scanner.sv
dv/tb_json_array_element_scanner.sv
